>>> rtl/hierarchical_tree_lock_manager_defines.svh
// ---------------------------------------------------------------------------
// Tree lock manager assertion macros
// Shared concurrent check forms; expect clk and rst_n in the using scope.
// ---------------------------------------------------------------------------
`ifndef HIERARCHICAL_TREE_LOCK_MANAGER_DEFINES_SVH
`define HIERARCHICAL_TREE_LOCK_MANAGER_DEFINES_SVH

// same-cycle implication
`define HTLM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htlm: check failed");

// next-cycle implication
`define HTLM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htlm: check failed");

`endif

>>> rtl/htlm_pkg.sv
// ---------------------------------------------------------------------------
// Tree lock manager package
// Field widths, operation and register codes, store request type.
// ---------------------------------------------------------------------------
package htlm_pkg;

  localparam int KIND_W     = 2;
  localparam int NODE_IDX_W = 8;
  localparam int BF_W       = 8;
  localparam int NC_W       = 9;
  localparam int CNT_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_LOCK    = 2'd0;
  localparam kind_t KIND_UNLOCK  = 2'd1;
  localparam kind_t KIND_UPGRADE = 2'd2;
  localparam kind_t KIND_NONE    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BRANCH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd1;

  localparam logic [BF_W-1:0] BF_RESET = 8'd2;
  localparam logic [NC_W-1:0] NC_RESET = 9'd256;

  typedef struct packed {
    logic             clear;
    logic             lk_we;
    logic             lk_val;
    logic             own_we;
    logic             cnt_we;
    logic [CNT_W-1:0] cnt_val;
  } st_req_t;

endpackage

>>> rtl/htlm_req_if.sv
// ---------------------------------------------------------------------------
// Tree lock manager request channel
// Valid/ready channel carrying one lock request.
// ---------------------------------------------------------------------------
interface htlm_req_if #(parameter int USER_ID_BITS = 16);
  import htlm_pkg::*;

  logic                    valid;
  logic                    ready;
  kind_t                   kind;
  logic [NODE_IDX_W-1:0]   node_index;
  logic [USER_ID_BITS-1:0] user_id;

  modport source (output valid, output kind, output node_index, output user_id, input ready);
  modport sink   (input valid, input kind, input node_index, input user_id, output ready);
endinterface

>>> rtl/htlm_res_if.sv
// ---------------------------------------------------------------------------
// Tree lock manager result channel
// Valid/ready channel carrying the grant of one request.
// ---------------------------------------------------------------------------
interface htlm_res_if;
  logic valid;
  logic ready;
  logic granted;

  modport source (output valid, output granted, input ready);
  modport sink   (input valid, input granted, output ready);
endinterface

>>> rtl/htlm_cfg_if.sv
// ---------------------------------------------------------------------------
// Tree lock manager configuration channel
// Valid/ready register write channel: register index and write data.
// ---------------------------------------------------------------------------
interface htlm_cfg_if;
  import htlm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

>>> rtl/htlm_div.sv
// ---------------------------------------------------------------------------
// Tree lock manager parent divider
// Bit-serial restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module htlm_div #(
  parameter int W = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [W-1:0]             dividend,
  input  logic [htlm_pkg::BF_W-1:0] divisor,
  output logic                     done,
  output logic [W-1:0]             quotient
);
  import htlm_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic            busy_r;
  logic            done_r;
  logic [CW-1:0]   cnt_r;
  logic [W-1:0]    quo_r;
  logic [BF_W-1:0] rem_r;
  logic [BF_W-1:0] dvs_r;

  logic [BF_W:0]   trial;
  logic [BF_W:0]   diff;
  logic            ge;
  logic [BF_W-1:0] rem_step;
  logic [W-1:0]    quo_step;

  assign trial    = {rem_r, quo_r[W-1]};
  assign ge       = trial >= {1'b0, dvs_r};
  assign diff     = trial - {1'b0, dvs_r};
  assign rem_step = ge ? diff[BF_W-1:0] : trial[BF_W-1:0];
  assign quo_step = W'({quo_r, ge});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_step;
      rem_r <= rem_step;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/htlm_store.sv
// ---------------------------------------------------------------------------
// Tree lock manager node store
// Lock bits, owner memory and descendant-lock counts with registered reads.
// ---------------------------------------------------------------------------
module htlm_store #(
  parameter int MAX_NODES    = 256,
  parameter int USER_ID_BITS = 16,
  localparam int NW          = $clog2(MAX_NODES)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  htlm_pkg::st_req_t          req,
  input  logic [NW-1:0]              addr,
  input  logic [NW-1:0]              lk_addr,
  input  logic [USER_ID_BITS-1:0]    own_val,
  output logic                       rd_locked,
  output logic [htlm_pkg::CNT_W-1:0] rd_cnt,
  output logic [USER_ID_BITS-1:0]    rd_owner
);
  import htlm_pkg::*;

  logic [MAX_NODES-1:0]    locked_r;
  logic [MAX_NODES-1:0]    cnt_vld_r;
  logic [CNT_W-1:0]        cnt_mem [MAX_NODES];
  logic [USER_ID_BITS-1:0] own_mem [MAX_NODES];

  logic                    rd_lk_r;
  logic                    rd_cv_r;
  logic [CNT_W-1:0]        rd_cnt_r;
  logic [USER_ID_BITS-1:0] rd_own_r;

  always_ff @(posedge clk) begin
    if (!rst_n || req.clear) begin
      locked_r  <= '0;
      cnt_vld_r <= '0;
    end else begin
      if (req.lk_we) begin
        locked_r[lk_addr] <= req.lk_val;
      end
      if (req.cnt_we) begin
        cnt_vld_r[addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.cnt_we) begin
      cnt_mem[addr] <= req.cnt_val;
    end
    if (req.own_we) begin
      own_mem[lk_addr] <= own_val;
    end
    rd_cnt_r <= cnt_mem[addr];
    rd_own_r <= own_mem[addr];
  end

  always_ff @(posedge clk) begin
    rd_lk_r <= locked_r[addr];
    rd_cv_r <= cnt_vld_r[addr];
  end

  assign rd_locked = rd_lk_r;
  assign rd_cnt    = rd_cv_r ? rd_cnt_r : '0;
  assign rd_owner  = rd_own_r;

endmodule

>>> rtl/hierarchical_tree_lock_manager.sv
// ---------------------------------------------------------------------------
// Hierarchical tree lock manager
// Walks: each step up the tree goes through the shared bit-serial parent
//   divider; lock and unlock take one or two walks.
// Throughput: one request at a time; the next is taken once the result is queued.
// Reset: all locks and counts clear, as on a write to the branch or count register.
// ---------------------------------------------------------------------------
`include "hierarchical_tree_lock_manager_defines.svh"

module hierarchical_tree_lock_manager #(
  parameter int MAX_NODES    = 256,
  parameter int USER_ID_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  htlm_req_if.sink   in_ch,
  htlm_res_if.source out_ch,
  htlm_cfg_if.sink   cfg_ch
);
  import htlm_pkg::*;

  localparam int NW   = $clog2(MAX_NODES);
  localparam int JW   = NW + 1;
  localparam int CMPW = (JW > NC_W) ? JW : NC_W;
  localparam int SW   = 4;

  localparam logic [SW-1:0] S_IDLE    = 4'd0;
  localparam logic [SW-1:0] S_RDW     = 4'd1;
  localparam logic [SW-1:0] S_CHK     = 4'd2;
  localparam logic [SW-1:0] S_ANC     = 4'd3;
  localparam logic [SW-1:0] S_ANC_DW  = 4'd4;
  localparam logic [SW-1:0] S_ANC_CHK = 4'd5;
  localparam logic [SW-1:0] S_ADJ     = 4'd6;
  localparam logic [SW-1:0] S_ADJ_DW  = 4'd7;
  localparam logic [SW-1:0] S_ADJ_WR  = 4'd8;
  localparam logic [SW-1:0] S_SCAN    = 4'd9;
  localparam logic [SW-1:0] S_SCAN_RD = 4'd10;
  localparam logic [SW-1:0] S_BEL     = 4'd11;
  localparam logic [SW-1:0] S_BEL_DW  = 4'd12;
  localparam logic [SW-1:0] S_DONE    = 4'd13;

  logic [SW-1:0]           state_r, state_nxt;
  logic [SW-1:0]           ret_r, ret_nxt;
  kind_t                   kind_r, kind_nxt;
  logic [NW-1:0]           node_r, node_nxt;
  logic [USER_ID_BITS-1:0] user_r, user_nxt;
  logic [NW-1:0]           d_r, d_nxt;
  logic [NW-1:0]           addr_r, addr_nxt;
  logic [NW-1:0]           adj_t_r, adj_t_nxt;
  logic [JW-1:0]           j_r, j_nxt;
  logic                    pass_r, pass_nxt;
  logic                    adj_up_r, adj_up_nxt;
  logic                    adj_scan_r, adj_scan_nxt;
  logic                    granted_r, granted_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_granted_r, out_granted_nxt;
  logic [BF_W-1:0]         bf_r;
  logic [NC_W-1:0]         nc_r;

  logic                    in_fire;
  logic                    cfg_fire;
  logic                    cfg_clear;
  logic [BF_W-1:0]         bf_eff;
  logic [CMPW-1:0]         nc_ext;
  logic [CMPW-1:0]         cnt_eff;
  logic                    in_ok;
  logic [JW-1:0]           j_inc;

  logic                    div_start;
  logic                    div_done;
  logic [NW-1:0]           div_q;

  st_req_t                 st_req;
  logic                    rd_locked;
  logic [CNT_W-1:0]        rd_cnt;
  logic [USER_ID_BITS-1:0] rd_owner;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign cfg_fire  = cfg_ch.valid && cfg_ch.ready;
  assign cfg_clear = cfg_fire && (cfg_ch.reg_index == CFG_BRANCH ||
                                  cfg_ch.reg_index == CFG_COUNT);

  assign bf_eff  = (bf_r == '0) ? BF_W'(1) : bf_r;
  assign nc_ext  = CMPW'(nc_r);
  assign cnt_eff = (nc_ext > CMPW'(MAX_NODES)) ? CMPW'(MAX_NODES) : nc_ext;
  assign in_ok   = (CMPW'(in_ch.node_index) < cnt_eff) && (in_ch.kind != KIND_NONE);
  assign j_inc   = j_r + JW'(1);

  assign in_ch.ready    = (state_r == S_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.granted = out_granted_r;
  assign cfg_ch.ready   = 1'b1;

  htlm_div #(.W(NW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (d_r - NW'(1)),
    .divisor  (bf_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  htlm_store #(.MAX_NODES(MAX_NODES), .USER_ID_BITS(USER_ID_BITS)) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (st_req),
    .addr      (addr_r),
    .lk_addr   (adj_t_r),
    .own_val   (user_r),
    .rd_locked (rd_locked),
    .rd_cnt    (rd_cnt),
    .rd_owner  (rd_owner)
  );

  always_comb begin
    state_nxt       = state_r;
    ret_nxt         = ret_r;
    kind_nxt        = kind_r;
    node_nxt        = node_r;
    user_nxt        = user_r;
    d_nxt           = d_r;
    addr_nxt        = addr_r;
    adj_t_nxt       = adj_t_r;
    j_nxt           = j_r;
    pass_nxt        = pass_r;
    adj_up_nxt      = adj_up_r;
    adj_scan_nxt    = adj_scan_r;
    granted_nxt     = granted_r;
    out_granted_nxt = out_granted_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    div_start       = 1'b0;
    st_req          = '0;
    st_req.clear    = cfg_clear;
    st_req.lk_val   = adj_up_r;
    st_req.cnt_val  = adj_up_r ? (rd_cnt + CNT_W'(1)) : (rd_cnt - CNT_W'(1));

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          kind_nxt = in_ch.kind;
          node_nxt = NW'(in_ch.node_index);
          user_nxt = in_ch.user_id;
          if (in_ok) begin
            addr_nxt  = NW'(in_ch.node_index);
            ret_nxt   = S_CHK;
            state_nxt = S_RDW;
          end else begin
            granted_nxt = 1'b0;
            state_nxt   = S_DONE;
          end
        end
      end
      S_RDW: begin
        state_nxt = ret_r;
      end
      S_CHK: begin
        granted_nxt = 1'b0;
        state_nxt   = S_DONE;
        priority if (kind_r == KIND_LOCK) begin
          if (!rd_locked && rd_cnt == '0) begin
            d_nxt     = node_r;
            state_nxt = S_ANC;
          end
        end else if (kind_r == KIND_UNLOCK) begin
          if (rd_locked && rd_owner == user_r) begin
            adj_t_nxt    = node_r;
            adj_up_nxt   = 1'b0;
            adj_scan_nxt = 1'b0;
            d_nxt        = node_r;
            state_nxt    = S_ADJ;
          end
        end else begin
          if (!rd_locked && rd_cnt != '0) begin
            j_nxt     = JW'(node_r) + JW'(1);
            pass_nxt  = 1'b0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_ANC: begin
        if (d_r == '0) begin
          if (kind_r == KIND_LOCK) begin
            adj_t_nxt    = node_r;
            adj_up_nxt   = 1'b1;
            adj_scan_nxt = 1'b0;
            d_nxt        = node_r;
            state_nxt    = S_ADJ;
          end else begin
            j_nxt     = JW'(node_r) + JW'(1);
            pass_nxt  = 1'b1;
            state_nxt = S_SCAN;
          end
        end else begin
          div_start = 1'b1;
          state_nxt = S_ANC_DW;
        end
      end
      S_ANC_DW: begin
        if (div_done) begin
          d_nxt     = div_q;
          addr_nxt  = div_q;
          ret_nxt   = S_ANC_CHK;
          state_nxt = S_RDW;
        end
      end
      S_ANC_CHK: begin
        if (rd_locked) begin
          granted_nxt = 1'b0;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_ANC;
        end
      end
      S_ADJ: begin
        if (d_r == '0) begin
          st_req.lk_we  = 1'b1;
          st_req.own_we = adj_up_r;
          if (adj_scan_r) begin
            j_nxt     = j_inc;
            state_nxt = S_SCAN;
          end else begin
            granted_nxt = 1'b1;
            state_nxt   = S_DONE;
          end
        end else begin
          div_start = 1'b1;
          state_nxt = S_ADJ_DW;
        end
      end
      S_ADJ_DW: begin
        if (div_done) begin
          d_nxt     = div_q;
          addr_nxt  = div_q;
          ret_nxt   = S_ADJ_WR;
          state_nxt = S_RDW;
        end
      end
      S_ADJ_WR: begin
        st_req.cnt_we = 1'b1;
        state_nxt     = S_ADJ;
      end
      S_SCAN: begin
        if (CMPW'(j_r) >= cnt_eff) begin
          if (!pass_r) begin
            d_nxt     = node_r;
            state_nxt = S_ANC;
          end else begin
            adj_t_nxt    = node_r;
            adj_up_nxt   = 1'b1;
            adj_scan_nxt = 1'b0;
            d_nxt        = node_r;
            state_nxt    = S_ADJ;
          end
        end else begin
          addr_nxt  = j_r[NW-1:0];
          ret_nxt   = S_SCAN_RD;
          state_nxt = S_RDW;
        end
      end
      S_SCAN_RD: begin
        if (!rd_locked || (!pass_r && rd_owner == user_r)) begin
          j_nxt     = j_inc;
          state_nxt = S_SCAN;
        end else begin
          d_nxt     = j_r[NW-1:0];
          state_nxt = S_BEL;
        end
      end
      S_BEL: begin
        div_start = 1'b1;
        state_nxt = S_BEL_DW;
      end
      S_BEL_DW: begin
        if (div_done) begin
          priority if (div_q == node_r) begin
            if (!pass_r) begin
              granted_nxt = 1'b0;
              state_nxt   = S_DONE;
            end else begin
              adj_t_nxt    = j_r[NW-1:0];
              adj_up_nxt   = 1'b0;
              adj_scan_nxt = 1'b1;
              d_nxt        = j_r[NW-1:0];
              state_nxt    = S_ADJ;
            end
          end else if (div_q < node_r) begin
            j_nxt     = j_inc;
            state_nxt = S_SCAN;
          end else begin
            d_nxt     = div_q;
            state_nxt = S_BEL;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_granted_nxt = granted_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r         <= ret_nxt;
    kind_r        <= kind_nxt;
    node_r        <= node_nxt;
    user_r        <= user_nxt;
    d_r           <= d_nxt;
    addr_r        <= addr_nxt;
    adj_t_r       <= adj_t_nxt;
    j_r           <= j_nxt;
    pass_r        <= pass_nxt;
    adj_up_r      <= adj_up_nxt;
    adj_scan_r    <= adj_scan_nxt;
    granted_r     <= granted_nxt;
    out_granted_r <= out_granted_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bf_r <= BF_RESET;
      nc_r <= NC_RESET;
    end else if (cfg_fire) begin
      if (cfg_ch.reg_index == CFG_BRANCH) begin
        bf_r <= cfg_ch.wdata[BF_W-1:0];
      end
      if (cfg_ch.reg_index == CFG_COUNT) begin
        nc_r <= cfg_ch.wdata[NC_W-1:0];
      end
    end
  end

  `HTLM_ASSERT_NEXT(a_busy_after_accept, in_fire && rst_n, state_r != S_IDLE)
  `HTLM_ASSERT_NOW(a_div_done_waited,
    div_done, state_r == S_ANC_DW || state_r == S_ADJ_DW || state_r == S_BEL_DW)
  `HTLM_ASSERT_NEXT(a_result_queued,
    state_r == S_DONE && (!out_valid_r || out_ch.ready) && rst_n, out_valid_r)
  `HTLM_ASSERT_NOW(a_check_valid_kind, state_r == S_CHK, kind_r != KIND_NONE)

endmodule

>>> verif/tb_hierarchical_tree_lock_manager.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tree lock manager testbench
// Sends lock, unlock and upgrade requests over several tree shapes and
// configuration extremes. A local model of the tree predicts each grant, and
// every result is compared in order against the predicted grants. Both
// channels stall at random except in the closing full-rate phase.
// ---------------------------------------------------------------------------
module tb_hierarchical_tree_lock_manager;
  import htlm_pkg::*;

  localparam int TREE_NODES = 256;
  localparam int USER_W     = 16;
  localparam int PEND_DEPTH = 16;
  localparam int unsigned LIMIT_NS = 120_000_000;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  htlm_req_if #(.USER_ID_BITS(USER_W)) in_ch ();
  htlm_res_if                          out_ch ();
  htlm_cfg_if                          cfg_ch ();

  hierarchical_tree_lock_manager #(
    .MAX_NODES   (TREE_NODES),
    .USER_ID_BITS(USER_W)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bit                    held       [TREE_NODES];
  logic [USER_W-1:0]     holder     [TREE_NODES];
  logic [CNT_W-1:0]      held_below [TREE_NODES];
  logic [BF_W-1:0]       tree_branch;
  logic [NC_W-1:0]       tree_size;
  logic [USER_W-1:0]     user_pool  [4];

  bit          grant_fifo [PEND_DEPTH];
  int unsigned put_count  = 0;
  int unsigned take_count = 0;
  int unsigned fail_count = 0;
  int unsigned sent_count = 0;
  bit          idle_en    = 1'b1;

  function automatic void clear_tree();
    for (int i = 0; i < TREE_NODES; i++) begin
      held[i]       = 1'b0;
      holder[i]     = '0;
      held_below[i] = '0;
    end
  endfunction

  function automatic int unsigned nodes_in_use();
    return (tree_size > TREE_NODES) ? TREE_NODES : 32'(tree_size);
  endfunction

  function automatic int unsigned parent_node(int unsigned n);
    int unsigned m;
    m = (tree_branch == '0) ? 1 : 32'(tree_branch);
    return (n - 1) / m;
  endfunction

  function automatic bit has_locked_ancestor(int unsigned n);
    while (n != 0) begin
      n = parent_node(n);
      if (held[n]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit descends_from(int unsigned d, int unsigned a);
    while (d != 0) begin
      d = parent_node(d);
      if (d == a) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void shift_counts(int unsigned n, bit up);
    while (n != 0) begin
      n = parent_node(n);
      held_below[n] = up ? held_below[n] + 1'b1 : held_below[n] - 1'b1;
    end
  endfunction

  function automatic bit try_lock(int unsigned n, logic [USER_W-1:0] user);
    if (held[n] || held_below[n] != 0 || has_locked_ancestor(n)) return 1'b0;
    shift_counts(n, 1'b1);
    held[n]   = 1'b1;
    holder[n] = user;
    return 1'b1;
  endfunction

  function automatic bit try_unlock(int unsigned n, logic [USER_W-1:0] user);
    if (!held[n] || holder[n] != user) return 1'b0;
    shift_counts(n, 1'b0);
    held[n]   = 1'b0;
    holder[n] = '0;
    return 1'b1;
  endfunction

  function automatic bit try_upgrade(int unsigned n, logic [USER_W-1:0] user);
    int unsigned span;
    bit          ok;
    span = nodes_in_use();
    ok   = !held[n] && held_below[n] != 0;
    for (int unsigned j = n + 1; ok && j < span; j++)
      if (held[j] && holder[j] != user && descends_from(j, n)) ok = 1'b0;
    if (ok && has_locked_ancestor(n)) ok = 1'b0;
    if (ok) begin
      for (int unsigned j = n + 1; j < span; j++)
        if (held[j] && descends_from(j, n)) void'(try_unlock(j, user));
      ok = try_lock(n, user);
    end
    return ok;
  endfunction

  function automatic bit predict_grant(kind_t k, logic [NODE_IDX_W-1:0] node,
                                       logic [USER_W-1:0] user);
    int unsigned n;
    n = 32'(node);
    if (n >= nodes_in_use()) return 1'b0;
    case (k)
      KIND_LOCK:    return try_lock(n, user);
      KIND_UNLOCK:  return try_unlock(n, user);
      KIND_UPGRADE: return try_upgrade(n, user);
      default:      return 1'b0;
    endcase
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_BRANCH) begin
      tree_branch = data[BF_W-1:0];
      clear_tree();
    end else if (idx == CFG_COUNT) begin
      tree_size = data[NC_W-1:0];
      clear_tree();
    end
  endfunction

  function automatic logic [USER_W-1:0] pick_user();
    if ($urandom_range(0, 99) < 85) return user_pool[$urandom_range(0, 3)];
    return USER_W'($urandom_range(0, 65535));
  endfunction

  function automatic bit find_locked(output int unsigned node);
    int unsigned start;
    int unsigned idx;
    start = $urandom_range(0, TREE_NODES - 1);
    node  = 0;
    for (int unsigned i = 0; i < TREE_NODES; i++) begin
      idx = (start + i) % TREE_NODES;
      if (held[idx]) begin
        node = idx;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void report_fail(string what, bit want, logic got);
    fail_count++;
    if (fail_count <= 10)
      $display("[%0t] grant mismatch (%s): expected %0b, actual %b", $realtime, what, want, got);
  endfunction

  always @(posedge clk) begin : check_grant
    bit want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (put_count == take_count) begin
        report_fail("no request pending", 1'b0, out_ch.granted);
      end else begin
        want = grant_fifo[take_count % PEND_DEPTH];
        take_count++;
        if (out_ch.granted !== want) report_fail("granted", want, out_ch.granted);
      end
    end
  end

  initial begin : result_backpressure
    out_ch.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (idle_en && $urandom_range(0, 1) == 1) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  task automatic send_request(input kind_t k, input logic [NODE_IDX_W-1:0] node,
                              input logic [USER_W-1:0] user);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= k;
    in_ch.node_index <= node;
    in_ch.user_id    <= user;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    grant_fifo[put_count % PEND_DEPTH] = predict_grant(k, node, user);
    put_count++;
    sent_count++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (put_count != take_count) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    apply_register(idx, data);
  endtask

  task automatic set_tree(input logic [BF_W-1:0] bf, input logic [NC_W-1:0] nc);
    drain_results();
    write_register(CFG_BRANCH, {1'b0, bf});
    write_register(CFG_COUNT, nc);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_random_request();
    int unsigned span;
    int unsigned roll;
    int unsigned n;
    kind_t                 k;
    logic [NODE_IDX_W-1:0] node;
    logic [USER_W-1:0]     user;
    span = nodes_in_use();
    roll = $urandom_range(0, 99);
    if (span != 0 && $urandom_range(0, 9) != 0) node = NODE_IDX_W'($urandom_range(0, span - 1));
    else node = NODE_IDX_W'($urandom_range(0, 255));
    user = pick_user();
    if (roll < 40) begin
      k = KIND_LOCK;
    end else if (roll < 65) begin
      k = KIND_UNLOCK;
      if ($urandom_range(0, 3) != 0 && find_locked(n)) begin
        node = NODE_IDX_W'(n);
        user = holder[n];
      end
    end else if (roll < 94) begin
      k = KIND_UPGRADE;
    end else begin
      k = KIND_NONE;
    end
    send_request(k, node, user);
  endtask

  task automatic send_upgrade_sequence();
    int unsigned       span;
    int unsigned       d;
    int unsigned       a;
    int unsigned       steps;
    logic [USER_W-1:0] user;
    span = nodes_in_use();
    if (span < 2) begin
      send_random_request();
    end else begin
      d    = $urandom_range(1, span - 1);
      user = pick_user();
      send_request(KIND_LOCK, NODE_IDX_W'(d), user);
      if ($urandom_range(0, 1) == 1)
        send_request(KIND_LOCK, NODE_IDX_W'($urandom_range(1, span - 1)), user);
      a     = d;
      steps = $urandom_range(1, 3);
      while (steps != 0 && a != 0) begin
        a = parent_node(a);
        steps--;
      end
      send_request(KIND_UPGRADE, NODE_IDX_W'(a),
                   ($urandom_range(0, 4) == 0) ? pick_user() : user);
      if ($urandom_range(0, 1) == 1) send_request(KIND_UNLOCK, NODE_IDX_W'(a), user);
    end
  endtask

  task automatic run_tree_phase(input logic [BF_W-1:0] bf, input logic [NC_W-1:0] nc,
                                input int unsigned quota);
    int unsigned stop_at;
    set_tree(bf, nc);
    stop_at = sent_count + quota;
    while (sent_count < stop_at) begin
      if ($urandom_range(0, 9) < 3) send_upgrade_sequence();
      else send_random_request();
    end
  endtask

  task automatic test_lock_paths();
    send_request(KIND_LOCK, 8'd255, 16'hFFFF);
    send_request(KIND_LOCK, 8'd0, 16'h0000);
    send_request(KIND_UNLOCK, 8'd255, 16'h0000);
    send_request(KIND_LOCK, 8'd254, 16'h0001);
    send_request(KIND_UPGRADE, 8'd63, 16'hFFFF);
    send_request(KIND_LOCK, 8'd255, 16'hFFFF);
    send_request(KIND_UPGRADE, 8'd0, 16'hFFFF);
    send_request(KIND_UNLOCK, 8'd63, 16'hFFFF);
    send_request(KIND_UPGRADE, 8'd5, 16'h0001);
    send_request(KIND_UPGRADE, 8'd254, 16'h0001);
    send_request(KIND_NONE, 8'd0, 16'h0001);
    send_request(KIND_UNLOCK, 8'd254, 16'h0001);
  endtask

  task automatic test_tree_shapes();
    // spare register indexes must leave the locks alone
    send_request(KIND_LOCK, 8'd10, 16'h00A5);
    drain_results();
    write_register(CFG_SPARE_LO, 9'h1FF);
    write_register(CFG_SPARE_HI, 9'h000);
    cfg_ch.valid <= 1'b0;
    send_request(KIND_UNLOCK, 8'd10, 16'h00A5);
    // reshaping drops every lock
    send_request(KIND_LOCK, 8'd10, 16'h00A5);
    set_tree(BF_RESET, NC_RESET);
    send_request(KIND_UNLOCK, 8'd10, 16'h00A5);
    set_tree(8'd255, 9'd1);
    send_request(KIND_LOCK, 8'd1, 16'h0002);
    send_request(KIND_UPGRADE, 8'd0, 16'h0002);
    set_tree(8'd3, 9'd0);
    send_request(KIND_LOCK, 8'd0, 16'h0002);
    set_tree(8'd0, 9'd8);
    send_request(KIND_LOCK, 8'd7, 16'h1234);
    send_request(KIND_UPGRADE, 8'd3, 16'h1234);
    set_tree(8'd4, 9'd511);
    send_request(KIND_LOCK, 8'd255, 16'h8000);
    send_request(KIND_UPGRADE, 8'd0, 16'h8000);
    set_tree(8'd1, 9'd256);
    send_request(KIND_LOCK, 8'd255, 16'h7FFF);
    send_request(KIND_LOCK, 8'd0, 16'h7FFF);
    send_request(KIND_UNLOCK, 8'd255, 16'h7FFF);
  endtask

  task automatic test_random_traffic();
    run_tree_phase(8'd2, 9'd64, 80);
    run_tree_phase(8'd3, 9'd40, 50);
    run_tree_phase(8'd1, 9'd12, 30);
    run_tree_phase(8'd255, 9'd256, 40);
    run_tree_phase(8'd0, 9'd10, 20);
    run_tree_phase(8'd4, 9'd300, 30);
  endtask

  task automatic test_full_rate();
    drain_results();
    idle_en = 1'b0;
    run_tree_phase(8'd2, 9'd30, 30);
  endtask

  initial begin : timeout_guard
    #(LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.kind       <= KIND_LOCK;
    in_ch.node_index <= '0;
    in_ch.user_id    <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.reg_index <= CFG_BRANCH;
    cfg_ch.wdata     <= '0;
    tree_branch = BF_RESET;
    tree_size   = NC_RESET;
    clear_tree();
    user_pool[0] = 16'h0000;
    user_pool[1] = 16'hFFFF;
    user_pool[2] = USER_W'($urandom_range(1, 65534));
    user_pool[3] = USER_W'($urandom_range(1, 65534));
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_lock_paths();
    test_tree_shapes();
    test_random_traffic();
    test_full_rate();

    drain_results();
    repeat (500) @(posedge clk);
    fail_count += put_count - take_count;
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl
rtl/htlm_pkg.sv
rtl/htlm_req_if.sv
rtl/htlm_res_if.sv
rtl/htlm_cfg_if.sv
rtl/htlm_div.sv
rtl/htlm_store.sv
rtl/hierarchical_tree_lock_manager.sv
verif/tb_hierarchical_tree_lock_manager.sv
